[rtl/core/skt_pkg.sv]
`default_nettype none

package skt_pkg;

    localparam int CAPACITY_DEFAULT = 64;

    // operation codes carried in the mode field
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;
    localparam logic [1:0] MODE_READ   = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_RANGE     = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] key;
        logic [15:0]        handle;
        logic [5:0]         position;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic [15:0]        out_handle;
        logic signed [31:0] out_key;
        logic [6:0]         entry_count;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] key;
        logic [15:0]        handle;
    } t_entry;

endpackage

`default_nettype wire

[rtl/core/sorted_key_table.sv]
// sorted_key_table: entries of (signed key, handle) kept in ascending key order
// in one single-port-read, single-port-write memory with a registered read.
// Input channel i_in_valid/o_in_ready carries one operation per transaction:
// insert, delete by key, lookup by key, or read by position. Output channel
// o_out_valid/i_out_ready returns exactly one result per operation.
// One operation is worked on at a time; the sequencer walks the memory, one
// entry per cycle, through a read-compare-write loop on the shared ports:
//   insert        : shift from the top down to the slot, then place the entry
//   delete        : search, then close the gap
//   lookup        : linear search from position 0
//   read, refused : one read by position, or a result at once with no walk
// A new operation is taken once the previous result sits in the output
// register, so a result waiting on a stalled receiver does not block the next
// operation's work; only the hand-over of the following result waits.
// Reset clears the entry count and the handshake state; memory contents are
// left as they are, since only positions below the count are ever read.
`default_nettype none

module sorted_key_table #(
    parameter int CAPACITY = skt_pkg::CAPACITY_DEFAULT
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  skt_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output skt_pkg::t_out_item  o_out_item
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS     = 3'd1;
    localparam logic [2:0] S_INS_PUT = 3'd2;
    localparam logic [2:0] S_SRCH    = 3'd3;
    localparam logic [2:0] S_DEL     = 3'd4;
    localparam logic [2:0] S_RDP     = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    // entry memory and its registered read data
    skt_pkg::t_entry r_mem [CAPACITY];
    skt_pkg::t_entry r_rdata;

    logic [2:0]          r_state, n_state;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_count, n_count;
    skt_pkg::t_in_item   r_item, n_item;
    skt_pkg::t_out_item  r_res, n_res;
    skt_pkg::t_out_item  r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    skt_pkg::t_entry     mem_wd;
    logic                mem_re;
    logic [AW-1:0]       mem_ra;

    logic [CW-1:0]       idx_p1;
    logic [CW-1:0]       idx_m1;
    logic [CW:0]         idx_p2;
    logic [31:0]         count_wide;
    skt_pkg::t_entry     new_entry;

    assign idx_p1     = r_idx + CW'(1);
    assign idx_m1     = r_idx - CW'(1);
    assign idx_p2     = {1'b0, r_idx} + (CW + 1)'(2);
    assign count_wide = 32'(r_count);
    assign new_entry  = '{key: r_item.key, handle: r_item.handle};

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_count     = r_count;
        n_item      = r_item;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        mem_we      = 1'b0;
        mem_wa      = '0;
        mem_wd      = r_rdata;
        mem_re      = 1'b0;
        mem_ra      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in_item;
                    n_res  = '0;
                    n_idx  = '0;
                    unique case (i_in_item.mode)
                        skt_pkg::MODE_INSERT: begin
                            if (r_count == CW'(CAPACITY)) begin
                                n_res.status = skt_pkg::STAT_FULL;
                                n_state      = S_DONE;
                            end else if (r_count == '0) begin
                                // empty table: place the entry at the bottom
                                mem_we  = 1'b1;
                                mem_wa  = '0;
                                mem_wd  = '{key: i_in_item.key, handle: i_in_item.handle};
                                n_count = r_count + CW'(1);
                                n_state = S_DONE;
                            end else begin
                                // walk down from the top, shifting greater keys up
                                n_idx   = r_count;
                                mem_re  = 1'b1;
                                mem_ra  = AW'(r_count - CW'(1));
                                n_state = S_INS;
                            end
                        end
                        skt_pkg::MODE_DELETE, skt_pkg::MODE_LOOKUP: begin
                            if (r_count == '0) begin
                                n_res.status = skt_pkg::STAT_NOT_FOUND;
                                n_state      = S_DONE;
                            end else begin
                                mem_re  = 1'b1;
                                mem_ra  = '0;
                                n_state = S_SRCH;
                            end
                        end
                        skt_pkg::MODE_READ: begin
                            if (32'(i_in_item.position) >= count_wide) begin
                                n_res.status = skt_pkg::STAT_RANGE;
                                n_state      = S_DONE;
                            end else begin
                                mem_re  = 1'b1;
                                mem_ra  = AW'(i_in_item.position);
                                n_state = S_RDP;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end

            S_INS: begin
                // r_rdata holds the entry just below slot r_idx
                mem_we = 1'b1;
                mem_wa = r_idx[AW-1:0];
                if (r_rdata.key > r_item.key) begin
                    mem_wd = r_rdata;
                    n_idx  = idx_m1;
                    if (idx_m1 == '0) begin
                        n_state = S_INS_PUT;
                    end else begin
                        mem_re = 1'b1;
                        mem_ra = AW'(idx_m1 - CW'(1));
                    end
                end else begin
                    mem_wd  = new_entry;
                    n_count = r_count + CW'(1);
                    n_state = S_DONE;
                end
            end

            S_INS_PUT: begin
                mem_we  = 1'b1;
                mem_wa  = r_idx[AW-1:0];
                mem_wd  = new_entry;
                n_count = r_count + CW'(1);
                n_state = S_DONE;
            end

            S_SRCH: begin
                if (r_rdata.key == r_item.key) begin
                    n_res.found      = 1'b1;
                    n_res.out_key    = r_rdata.key;
                    n_res.out_handle = r_rdata.handle;
                    if (r_item.mode == skt_pkg::MODE_LOOKUP) begin
                        n_state = S_DONE;
                    end else if (idx_p1 < r_count) begin
                        // close the gap from the entry above
                        mem_re  = 1'b1;
                        mem_ra  = idx_p1[AW-1:0];
                        n_state = S_DEL;
                    end else begin
                        n_count = r_count - CW'(1);
                        n_state = S_DONE;
                    end
                end else if (idx_p1 == r_count) begin
                    n_res.status = skt_pkg::STAT_NOT_FOUND;
                    n_state      = S_DONE;
                end else begin
                    n_idx  = idx_p1;
                    mem_re = 1'b1;
                    mem_ra = idx_p1[AW-1:0];
                end
            end

            S_DEL: begin
                // r_rdata holds the entry at r_idx + 1; move it down
                mem_we = 1'b1;
                mem_wa = r_idx[AW-1:0];
                mem_wd = r_rdata;
                n_idx  = idx_p1;
                if (idx_p2 < {1'b0, r_count}) begin
                    mem_re = 1'b1;
                    mem_ra = idx_p2[AW-1:0];
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end

            S_RDP: begin
                n_res.found      = 1'b1;
                n_res.out_key    = r_rdata.key;
                n_res.out_handle = r_rdata.handle;
                n_state          = S_DONE;
            end

            S_DONE: begin
                // hand over once the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out             = r_res;
                    n_out.entry_count = count_wide[6:0];
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_item <= n_item;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

endmodule

`default_nettype wire
